[rtl/bfra_pkg.sv]
// shared types, sizes and codes of the best-fit region allocator
// used by bfra_cell and best_fit_region_allocator_unit, depends on nothing
`default_nettype none

package bfra_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int ADDR_BITS   = 20;
    localparam int REG_W       = ADDR_BITS + 1;            // region bounds and size
    localparam int IDX_W       = $clog2(MAX_REGIONS);      // cell index
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);  // region count
    localparam int SUM_W       = ADDR_BITS + 2;            // addr + size before range check

    localparam int IN_W  = 2 + ADDR_BITS + REG_W;
    localparam int OUT_W = 2 + ADDR_BITS + CNT_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // commands
    localparam logic [1:0] CMD_FREE  = 2'd0;
    localparam logic [1:0] CMD_FIXED = 2'd1;
    localparam logic [1:0] CMD_BEST  = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    // cell update operations
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_SET_FIRST = 3'd1;
    localparam logic [2:0] OP_SET_LAST  = 3'd2;
    localparam logic [2:0] OP_DROP      = 3'd3;
    localparam logic [2:0] OP_MERGE     = 3'd4;
    localparam logic [2:0] OP_OPEN      = 3'd5;
    localparam logic [2:0] OP_SPLIT     = 3'd6;

    // per-cell compare results against the current command
    typedef struct packed {
        logic overlap;
        logic lower;
        logic touch_left;
        logic touch_right;
        logic contain;
        logic at_start;
        logic at_end;
    } t_cell_flags;

    // best-fit candidate passed along the row
    typedef struct packed {
        logic             found;
        logic [REG_W-1:0] len;
        logic [REG_W-1:0] first;
        logic [IDX_W-1:0] idx;
    } t_cand;

    // table update broadcast to all cells
    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] k;
        logic [REG_W-1:0] v_first;
        logic [REG_W-1:0] v_last;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/bfra_cell.sv]
// one table entry of the region allocator: bounds, compares, best-fit stage
// depends on bfra_pkg
`default_nettype none

module bfra_cell
    import bfra_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic [CNT_W-1:0] i_total,
    input  wire logic [REG_W-1:0] i_lo,
    input  wire logic [REG_W-1:0] i_hi,
    input  wire logic [REG_W-1:0] i_size,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [REG_W-1:0] i_left_first,
    input  wire logic [REG_W-1:0] i_left_last,
    input  wire logic [REG_W-1:0] i_right_first,
    input  wire logic [REG_W-1:0] i_right_last,
    input  wire t_cand            i_left_cand,
    output logic [REG_W-1:0]      o_first,
    output logic [REG_W-1:0]      o_last,
    output t_cell_flags           o_flags,
    output t_cand                 o_cand
);

    logic [REG_W-1:0] r_first;
    logic [REG_W-1:0] r_last;
    t_cand            r_cand;
    t_cand            n_cand;
    logic             w_valid;
    logic [REG_W-1:0] w_len;
    logic             w_fit;
    logic [IDX_W:0]   w_idx_x;
    logic [IDX_W:0]   w_k_x;

    assign w_valid = {1'b0, i_idx} < i_total;
    assign w_len   = r_last - r_first;
    assign w_fit   = w_valid && (w_len >= i_size);
    assign w_idx_x = {1'b0, i_idx};
    assign w_k_x   = {1'b0, i_ctl.k};

    always_comb begin
        o_flags.overlap     = w_valid && (i_lo < r_last) && (i_hi > r_first);
        o_flags.lower       = w_valid && (r_first < i_lo);
        o_flags.touch_left  = r_last == i_lo;
        o_flags.touch_right = r_first == i_hi;
        o_flags.contain     = w_valid && (r_first <= i_lo) && (i_hi <= r_last);
        o_flags.at_start    = r_first == i_lo;
        o_flags.at_end      = r_last == i_hi;
    end

    // keep the smaller fit, earlier cell wins a tie
    always_comb begin
        n_cand = i_left_cand;
        if (w_fit && (!i_left_cand.found || (w_len < i_left_cand.len))) begin
            n_cand.found = 1'b1;
            n_cand.len   = w_len;
            n_cand.first = r_first;
            n_cand.idx   = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_SET_FIRST: begin
                if (i_idx == i_ctl.k) begin
                    r_first <= i_ctl.v_first;
                end
            end
            OP_SET_LAST: begin
                if (i_idx == i_ctl.k) begin
                    r_last <= i_ctl.v_last;
                end
            end
            OP_DROP: begin
                if (i_idx >= i_ctl.k) begin
                    r_first <= i_right_first;
                    r_last  <= i_right_last;
                end
            end
            OP_MERGE: begin
                if (w_idx_x + 1'b1 == w_k_x) begin
                    r_last <= i_right_last;
                end else if (i_idx >= i_ctl.k) begin
                    r_first <= i_right_first;
                    r_last  <= i_right_last;
                end
            end
            OP_OPEN: begin
                if (i_idx == i_ctl.k) begin
                    r_first <= i_ctl.v_first;
                    r_last  <= i_ctl.v_last;
                end else if (i_idx > i_ctl.k) begin
                    r_first <= i_left_first;
                    r_last  <= i_left_last;
                end
            end
            OP_SPLIT: begin
                if (i_idx == i_ctl.k) begin
                    r_last <= i_ctl.v_last;
                end else if (w_idx_x == w_k_x + 1'b1) begin
                    r_first <= i_ctl.v_first;
                    r_last  <= i_left_last;
                end else if (w_idx_x > w_k_x + 1'b1) begin
                    r_first <= i_left_first;
                    r_last  <= i_left_last;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_first = r_first;
    assign o_last  = r_last;
    assign o_cand  = r_cand;

endmodule

`default_nettype wire

[rtl/best_fit_region_allocator_unit.sv]
// top level of the best-fit region allocator: command control and row of table cells
// depends on bfra_pkg and bfra_cell
`default_nettype none

// The unit keeps an address-ordered table of up to MAX_REGIONS free regions, each a
// half-open range [first, last), held one per cell in a row of identical cells.
// Each input transfer carries one command: free a range (merging with touching
// neighbors), allocate a given range, or allocate best fit (smallest region that is
// large enough, earliest on a tie, cut from its start). One output transfer returns
// the status, the granted address and the number of free regions held afterwards.
// Commands are taken one at a time. A command that fails its range check, or the
// reserved command code, goes straight from acceptance to result valid. Any other
// command passes the scan, decide and apply states: the best-fit candidate ripples
// through the row one cell per cycle, then the decide state picks the table update
// and the apply state applies it, with every cell shifting from its neighbor
// at once. A new command is accepted once the previous result has been taken.
// The table content is undefined after reset; only entries below the count are used.

module best_fit_region_allocator_unit
    import bfra_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input channel
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cmd[1:0], addr[21:2], size[42:22]
    // output channel
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // status[1:0], granted_addr[21:2],
                                                        // free_count[26:22]
);

    // control states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_APPLY  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    localparam logic [SUM_W-1:0] SPACE = SUM_W'(1) << ADDR_BITS;
    localparam logic [CNT_W-1:0] FULL  = CNT_W'(MAX_REGIONS);
    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(MAX_REGIONS - 1);

    logic [2:0]           r_state;
    logic [IDX_W-1:0]     r_cnt;
    logic [1:0]           r_cmd;
    logic [REG_W-1:0]     r_lo;
    logic [REG_W-1:0]     r_hi;
    logic [REG_W-1:0]     r_size;
    logic [CNT_W-1:0]     r_total;
    logic [1:0]           r_status;
    logic [ADDR_BITS-1:0] r_grant;
    t_cell_ctl            r_ctl;

    logic [1:0]           n_status;
    logic [ADDR_BITS-1:0] n_grant;
    t_cell_ctl            n_ctl;

    // input field split
    logic [1:0]           w_cmd;
    logic [ADDR_BITS-1:0] w_addr;
    logic [REG_W-1:0]     w_size;
    logic [SUM_W-1:0]     w_end;
    logic                 w_bad_range;

    // row wiring
    logic [REG_W-1:0] w_first [MAX_REGIONS];
    logic [REG_W-1:0] w_last  [MAX_REGIONS];
    t_cand            w_cand  [MAX_REGIONS];
    t_cell_flags      w_flags [MAX_REGIONS];
    t_cell_flags      r_flags [MAX_REGIONS];

    // decision helpers
    logic [MAX_REGIONS-1:0] w_ovl;
    logic [MAX_REGIONS-1:0] w_lower;
    logic [MAX_REGIONS-1:0] w_tl;
    logic [MAX_REGIONS-1:0] w_tr;
    logic [MAX_REGIONS-1:0] w_contain;
    logic [CNT_W-1:0]       w_pos;
    logic [IDX_W-1:0]       w_pos_m1;
    logic [IDX_W-1:0]       w_hit;
    logic                   w_left;
    logic                   w_right;
    t_cand                  w_best;

    assign w_cmd  = s_axis_tdata[1:0];
    assign w_addr = s_axis_tdata[2 +: ADDR_BITS];
    assign w_size = s_axis_tdata[2 + ADDR_BITS +: REG_W];

    // end of the range: size alone for best fit, addr + size otherwise
    always_comb begin
        if (w_cmd == CMD_BEST) begin
            w_end = {1'b0, w_size};
        end else begin
            w_end = {2'b00, w_addr} + {1'b0, w_size};
        end
        w_bad_range = (w_size == '0) || (w_end > SPACE);
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_state == S_OUT;
    assign m_axis_tdata  = OUT_TDATA_W'({r_total, r_grant, r_status});

    // row of table cells, neighbors wired both ways
    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        logic [REG_W-1:0] w_lf;
        logic [REG_W-1:0] w_ll;
        logic [REG_W-1:0] w_rf;
        logic [REG_W-1:0] w_rl;
        t_cand            w_lc;

        if (g == 0) begin : g_head
            assign w_lf = '0;
            assign w_ll = '0;
            assign w_lc = '0;
        end else begin : g_mid
            assign w_lf = w_first[g-1];
            assign w_ll = w_last[g-1];
            assign w_lc = w_cand[g-1];
        end

        if (g == MAX_REGIONS - 1) begin : g_tail
            assign w_rf = '0;
            assign w_rl = '0;
        end else begin : g_body
            assign w_rf = w_first[g+1];
            assign w_rl = w_last[g+1];
        end

        bfra_cell u_cell (
            .i_clk         (i_clk),
            .i_idx         (IDX_W'(g)),
            .i_total       (r_total),
            .i_lo          (r_lo),
            .i_hi          (r_hi),
            .i_size        (r_size),
            .i_ctl         (r_ctl),
            .i_left_first  (w_lf),
            .i_left_last   (w_ll),
            .i_right_first (w_rf),
            .i_right_last  (w_rl),
            .i_left_cand   (w_lc),
            .o_first       (w_first[g]),
            .o_last        (w_last[g]),
            .o_flags       (w_flags[g]),
            .o_cand        (w_cand[g])
        );
    end

    // compare results are held for the decide cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_flags <= w_flags;
        end
    end

    // flatten registered flags, find insert position and containing region
    always_comb begin
        w_hit = '0;
        for (int i = 0; i < MAX_REGIONS; i++) begin
            w_ovl[i]     = r_flags[i].overlap;
            w_lower[i]   = r_flags[i].lower;
            w_tl[i]      = r_flags[i].touch_left;
            w_tr[i]      = r_flags[i].touch_right;
            w_contain[i] = r_flags[i].contain;
        end
        for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
            if (w_contain[i]) begin
                w_hit = IDX_W'(i);
            end
        end
    end

    // held regions below the new range form a prefix, so their count is the slot
    assign w_pos    = CNT_W'($countones(w_lower));
    assign w_pos_m1 = IDX_W'(w_pos - 1'b1);
    assign w_left   = (w_pos != '0) && w_tl[w_pos_m1];
    assign w_right  = (w_pos < r_total) && w_tr[w_pos[IDX_W-1:0]];
    assign w_best   = w_cand[MAX_REGIONS-1];

    // choose status and table update
    always_comb begin
        n_status      = ST_DONE;
        n_grant       = r_grant;
        n_ctl.op      = OP_NONE;
        n_ctl.k       = '0;
        n_ctl.v_first = '0;
        n_ctl.v_last  = '0;
        case (r_cmd)
            CMD_FREE: begin
                if (|w_ovl) begin
                    n_status = ST_NOFIT;
                end else if (w_left && w_right) begin
                    // bridge: left neighbor takes the right one's end, right one leaves
                    n_ctl.op = OP_MERGE;
                    n_ctl.k  = w_pos[IDX_W-1:0];
                end else if (w_left) begin
                    n_ctl.op     = OP_SET_LAST;
                    n_ctl.k      = w_pos_m1;
                    n_ctl.v_last = r_hi;
                end else if (w_right) begin
                    n_ctl.op      = OP_SET_FIRST;
                    n_ctl.k       = w_pos[IDX_W-1:0];
                    n_ctl.v_first = r_lo;
                end else if (r_total >= FULL) begin
                    n_status = ST_FULL;
                end else begin
                    n_ctl.op      = OP_OPEN;
                    n_ctl.k       = w_pos[IDX_W-1:0];
                    n_ctl.v_first = r_lo;
                    n_ctl.v_last  = r_hi;
                end
            end
            CMD_FIXED: begin
                if (!(|w_contain)) begin
                    n_status = ST_NOFIT;
                end else if (r_flags[w_hit].at_start && r_flags[w_hit].at_end) begin
                    n_ctl.op = OP_DROP;
                    n_ctl.k  = w_hit;
                end else if (r_flags[w_hit].at_start) begin
                    n_ctl.op      = OP_SET_FIRST;
                    n_ctl.k       = w_hit;
                    n_ctl.v_first = r_hi;
                end else if (r_flags[w_hit].at_end) begin
                    n_ctl.op     = OP_SET_LAST;
                    n_ctl.k      = w_hit;
                    n_ctl.v_last = r_lo;
                end else if (r_total >= FULL) begin
                    n_status = ST_FULL;
                end else begin
                    // middle cut: region keeps the low part, next cell gets the high part
                    n_ctl.op      = OP_SPLIT;
                    n_ctl.k       = w_hit;
                    n_ctl.v_first = r_hi;
                    n_ctl.v_last  = r_lo;
                end
            end
            CMD_BEST: begin
                if (!w_best.found) begin
                    n_status = ST_NOFIT;
                end else begin
                    n_grant = w_best.first[ADDR_BITS-1:0];
                    n_ctl.k = w_best.idx;
                    if (w_best.len == r_size) begin
                        n_ctl.op = OP_DROP;
                    end else begin
                        n_ctl.op      = OP_SET_FIRST;
                        n_ctl.v_first = w_best.first + r_size;
                    end
                end
            end
            default: begin
                n_status = ST_NOFIT;
            end
        endcase
    end

    // command control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_total  <= '0;
            r_ctl.op <= OP_NONE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_ctl.op <= OP_NONE;
                    if (s_axis_tvalid) begin
                        r_cnt <= '0;
                        if (w_bad_range) begin
                            r_state <= S_OUT;
                        end else if (w_cmd inside {CMD_FREE, CMD_FIXED, CMD_BEST}) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SCAN: begin
                    // candidate moves one cell per cycle toward the row end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_CELL) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_ctl   <= n_ctl;
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_ctl.op <= OP_NONE;
                    case (r_ctl.op)
                        OP_DROP, OP_MERGE: r_total <= r_total - 1'b1;
                        OP_OPEN, OP_SPLIT: r_total <= r_total + 1'b1;
                        default: begin
                        end
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_ctl.op <= OP_NONE;
                end
            endcase
        end
    end

    // command payload and result fields
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_cmd  <= w_cmd;
            r_lo   <= {1'b0, w_addr};
            r_hi   <= w_end[REG_W-1:0];
            r_size <= w_size;
            if (w_cmd == CMD_BEST) begin
                r_grant <= '0;
            end else begin
                r_grant <= w_addr;
            end
            // the reserved code reports no fit whatever its range
            if (w_bad_range && (w_cmd inside {CMD_FREE, CMD_FIXED, CMD_BEST})) begin
                r_status <= ST_RANGE;
            end else begin
                r_status <= ST_NOFIT;
            end
        end else if (r_state == S_DECIDE) begin
            r_status <= n_status;
            r_grant  <= n_grant;
        end
    end

endmodule

`default_nettype wire

[test/best_fit_region_allocator_unit_tb.sv]
// self-checking testbench of best_fit_region_allocator_unit: directed and random commands
// depends on bfra_pkg and the allocator rtl, predicts every result with its own region table
`default_nettype none

module best_fit_region_allocator_unit_tb
    import bfra_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // reserved command code, ignored by the block with a no-fit status
    localparam logic [1:0] CMD_RSVD = 2'd3;
    localparam logic [SUM_W-1:0] SPACE = SUM_W'(1) << ADDR_BITS;
    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT = 3000;
    // settle time after the last result, above the command latency
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] grant;
        logic [CNT_W-1:0]     count;
    } t_alloc_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // cmd, addr, size from bit 0 up
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // status, granted_addr, free_count

    best_fit_region_allocator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // own copy of the free-region table, address ordered, half-open ranges
    logic [SUM_W-1:0] tbl_first [MAX_REGIONS];
    logic [SUM_W-1:0] tbl_last  [MAX_REGIONS];
    int               tbl_count = 0;

    t_alloc_result pending_results [$];
    int            err_count = 0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    int            rx_cycle = 0;
    int            rx_hold_end = 0;
    int            quiet_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // region table predictor
    // ------------------------------------------------------------------

    // remove entry k, closing the hole
    function automatic void tbl_drop(input int k);
        for (int j = k; j + 1 < tbl_count; j++) begin
            tbl_first[j] = tbl_first[j + 1];
            tbl_last[j]  = tbl_last[j + 1];
        end
        tbl_count--;
    endfunction

    // insert a new entry at position k, shifting the tail up
    function automatic void tbl_open(input int k, input logic [SUM_W-1:0] lo, hi);
        for (int j = tbl_count; j > k; j--) begin
            tbl_first[j] = tbl_first[j - 1];
            tbl_last[j]  = tbl_last[j - 1];
        end
        tbl_first[k] = lo;
        tbl_last[k]  = hi;
        tbl_count++;
    endfunction

    // give a range back, merging with touching neighbors
    function automatic logic [1:0] tbl_release(input logic [SUM_W-1:0] lo, hi);
        int pos;
        bit left, right;
        pos = 0;
        left = 1'b0;
        right = 1'b0;
        for (int i = 0; i < tbl_count; i++) begin
            if (lo < tbl_last[i] && hi > tbl_first[i])
                return ST_NOFIT;
            if (tbl_first[i] < lo)
                pos = i + 1;
        end
        if (pos > 0)
            left = (tbl_last[pos - 1] == lo);
        if (pos < tbl_count)
            right = (tbl_first[pos] == hi);
        if (left && right) begin
            tbl_last[pos - 1] = tbl_last[pos];
            tbl_drop(pos);
        end else if (left) begin
            tbl_last[pos - 1] = hi;
        end else if (right) begin
            tbl_first[pos] = lo;
        end else begin
            if (tbl_count >= MAX_REGIONS)
                return ST_FULL;
            tbl_open(pos, lo, hi);
        end
        return ST_DONE;
    endfunction

    // carve a given range out of the one region that holds it
    function automatic logic [1:0] tbl_carve(input logic [SUM_W-1:0] lo, hi);
        bit at_start, at_end;
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_first[i] <= lo && hi <= tbl_last[i]) begin
                at_start = (tbl_first[i] == lo);
                at_end   = (tbl_last[i] == hi);
                if (at_start && at_end) begin
                    tbl_drop(i);
                end else if (at_start) begin
                    tbl_first[i] = hi;
                end else if (at_end) begin
                    tbl_last[i] = lo;
                end else begin
                    if (tbl_count >= MAX_REGIONS)
                        return ST_FULL;
                    tbl_open(i + 1, hi, tbl_last[i]);
                    tbl_last[i] = lo;
                end
                return ST_DONE;
            end
        end
        return ST_NOFIT;
    endfunction

    // smallest region that fits, earliest on a tie, cut from its start
    function automatic logic [1:0] tbl_best_fit(input logic [SUM_W-1:0] size,
                                                output logic [SUM_W-1:0] start);
        int pick;
        logic [SUM_W-1:0] len, best_len;
        pick = -1;
        best_len = '0;
        start = '0;
        for (int i = 0; i < tbl_count; i++) begin
            len = tbl_last[i] - tbl_first[i];
            if (len >= size && (pick < 0 || len < best_len)) begin
                pick = i;
                best_len = len;
            end
        end
        if (pick < 0)
            return ST_NOFIT;
        start = tbl_first[pick];
        if (best_len == size)
            tbl_drop(pick);
        else
            tbl_first[pick] = tbl_first[pick] + size;
        return ST_DONE;
    endfunction

    // result of one command, table updated in place
    function automatic t_alloc_result predict_alloc(input logic [1:0] cmd,
                                                    input logic [ADDR_BITS-1:0] addr,
                                                    input logic [REG_W-1:0] size);
        t_alloc_result r;
        logic [SUM_W-1:0] lo, hi, start;
        lo = SUM_W'(addr);
        hi = SUM_W'(addr) + SUM_W'(size);
        r.grant = addr;
        if (cmd == CMD_BEST) begin
            r.grant = '0;
            if (size == '0 || SUM_W'(size) > SPACE) begin
                r.status = ST_RANGE;
            end else begin
                r.status = tbl_best_fit(SUM_W'(size), start);
                r.grant = start[ADDR_BITS-1:0];
            end
        end else if (cmd == CMD_RSVD) begin
            r.status = ST_NOFIT;
        end else if (size == '0 || hi > SPACE) begin
            r.status = ST_RANGE;
        end else if (cmd == CMD_FREE) begin
            r.status = tbl_release(lo, hi);
        end else begin
            r.status = tbl_carve(lo, hi);
        end
        r.count = CNT_W'(tbl_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one command transfer; the prediction is made once the block takes it
    task automatic send_cmd(input logic [1:0] cmd, input logic [ADDR_BITS-1:0] addr,
                            input logic [REG_W-1:0] size);
        int gap;
        gap = 0;
        while (tx_idle_pct > 0 && gap < 40 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({size, addr, cmd});
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_alloc(cmd, addr, size));
    endtask

    // sub-range of [lo, hi), often touching one end or covering it all
    task automatic pick_span(input logic [SUM_W-1:0] lo, hi,
                             output logic [SUM_W-1:0] start, len);
        logic [SUM_W-1:0] room;
        room = hi - lo;
        if (room > 16 && $urandom_range(0, 9) < 6)
            len = SUM_W'($urandom_range(1, 16));
        else
            len = SUM_W'($urandom_range(1, room));
        case ($urandom_range(0, 5))
            0: begin
                start = lo;
                len = room;
            end
            1: start = lo;
            2: start = hi - len;
            default: start = lo + SUM_W'($urandom_range(0, room - len));
        endcase
    endtask

    function automatic int widest_region();
        int w;
        w = 0;
        for (int i = 1; i < tbl_count; i++)
            if (tbl_last[i] - tbl_first[i] > tbl_last[w] - tbl_first[w])
                w = i;
        return w;
    endfunction

    // command shaped by the current table: frees into gaps, carves from regions,
    // best fit sized against a held region; a small share is plain noise
    task automatic send_random_cmd();
        int kind, g;
        logic [SUM_W-1:0] lo, hi, start, len;
        logic [1:0] cmd;
        logic [REG_W-1:0] size;
        kind = $urandom_range(0, 19);
        if (tbl_count == 0 && kind >= 7 && kind < 17)
            kind = 0;
        if (kind < 7) begin
            // free inside a gap between held regions
            g = $urandom_range(0, tbl_count);
            lo = (g == 0) ? '0 : tbl_last[(g == 0) ? 0 : g - 1];
            hi = (g == tbl_count) ? SPACE : tbl_first[(g == tbl_count) ? 0 : g];
            if (hi > lo) begin
                pick_span(lo, hi, start, len);
            end else begin
                start = SUM_W'($urandom_range(0, SPACE - 1));
                len = SUM_W'($urandom_range(1, 64));
            end
            send_cmd(CMD_FREE, start[ADDR_BITS-1:0], len[REG_W-1:0]);
        end else if (kind < 12) begin
            g = $urandom_range(0, tbl_count - 1);
            pick_span(tbl_first[g], tbl_last[g], start, len);
            send_cmd(CMD_FIXED, start[ADDR_BITS-1:0], len[REG_W-1:0]);
        end else if (kind < 17) begin
            g = $urandom_range(0, tbl_count - 1);
            len = tbl_last[g] - tbl_first[g];
            case ($urandom_range(0, 2))
                0: size = len[REG_W-1:0];
                1: size = REG_W'($urandom_range(1, len));
                default: size = (len < SPACE) ? REG_W'(len + 1) : len[REG_W-1:0];
            endcase
            send_cmd(CMD_BEST, ADDR_BITS'($urandom), size);
        end else begin
            cmd = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 2))
                0: size = REG_W'($urandom_range(0, 8));
                1: size = REG_W'($urandom);
                default: size = REG_W'(SPACE) - REG_W'($urandom_range(0, 3));
            endcase
            send_cmd(cmd, ADDR_BITS'($urandom), size);
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, long hold-off on request, field checks
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_side
        t_alloc_result want;
        rx_cycle <= rx_cycle + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result transfer with nothing pending", m_axis_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                    report_mismatch("status", 32'(m_axis_tdata[1:0]), 32'(want.status));
                if (m_axis_tdata[ADDR_BITS+1:2] !== want.grant)
                    report_mismatch("granted_addr", 32'(m_axis_tdata[ADDR_BITS+1:2]),
                                    32'(want.grant));
                if (m_axis_tdata[ADDR_BITS+CNT_W+1:ADDR_BITS+2] !== want.count)
                    report_mismatch("free_count",
                                    32'(m_axis_tdata[ADDR_BITS+CNT_W+1:ADDR_BITS+2]),
                                    32'(want.count));
            end
        end
        if (rx_cycle < rx_hold_end)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog: a hung block shows as a long run of cycles with no transfer at all
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // range errors, the reserved code and a best fit on an empty table
    task automatic test_range_and_reserved();
        send_cmd(CMD_BEST, '0, 21'd4);                 // nothing held yet
        send_cmd(CMD_RSVD, '1, '1);
        send_cmd(CMD_FREE, 20'h12345, '0);             // zero size
        send_cmd(CMD_FREE, '1, 21'd2);                 // end one past the space
        send_cmd(CMD_FIXED, 20'h80000, 21'h100000);
        send_cmd(CMD_BEST, '0, 21'h100001);            // best fit larger than the space
        send_cmd(CMD_BEST, '0, '0);
    endtask

    // free with overlap, merges on both sides, one side, and none
    task automatic test_free_merge();
        send_cmd(CMD_FREE, '0, 21'h100000);            // whole space in one transfer
        send_cmd(CMD_FREE, 20'h100, 21'h100);          // overlaps
        send_cmd(CMD_FIXED, 20'h100, 21'h10);          // split
        send_cmd(CMD_FREE, 20'h100, 21'h10);           // touches both sides
        send_cmd(CMD_FIXED, 20'h200, 21'h100);
        send_cmd(CMD_FREE, 20'h280, 21'h10);           // isolated, new entry
        send_cmd(CMD_FREE, 20'h200, 21'h10);           // joins the left neighbor
        send_cmd(CMD_FREE, 20'h2f0, 21'h10);           // joins the right neighbor
    endtask

    // fixed allocation at the start, the end, exact, not held, straddling
    task automatic test_carve();
        send_cmd(CMD_FIXED, '0, 21'h10);
        send_cmd(CMD_FIXED, 20'hffff0, 21'h10);
        send_cmd(CMD_FIXED, 20'h280, 21'h10);
        send_cmd(CMD_FIXED, 20'h280, 21'h10);
        send_cmd(CMD_FIXED, 20'h208, 21'h10);
    endtask

    // exact fit removal, smallest pick, tie to the earliest, no fit, top address
    task automatic test_best_fit();
        send_cmd(CMD_BEST, '1, 21'h200);
        send_cmd(CMD_FREE, 20'h10, 21'h100);
        send_cmd(CMD_FREE, 20'h200, 21'h80);
        send_cmd(CMD_BEST, '0, 21'h80);
        send_cmd(CMD_BEST, '0, 21'h40);
        send_cmd(CMD_BEST, '0, 21'h100000);
        send_cmd(CMD_FREE, 20'h200, 21'hc0);           // equal in size to the first region
        send_cmd(CMD_BEST, '0, 21'h20);
        send_cmd(CMD_FREE, '1, 21'd1);
        send_cmd(CMD_FIXED, '1, 21'd1);
    endtask

    // split the widest region until the table is full, then a split and an
    // isolated free must both report a full table
    task automatic test_table_full();
        int w;
        logic [SUM_W-1:0] mid;
        while (tbl_count < MAX_REGIONS) begin
            w = widest_region();
            mid = tbl_first[w] + ((tbl_last[w] - tbl_first[w]) >> 1);
            send_cmd(CMD_FIXED, mid[ADDR_BITS-1:0], 21'd1);
        end
        w = widest_region();
        mid = tbl_first[w] + ((tbl_last[w] - tbl_first[w]) >> 1);
        send_cmd(CMD_FIXED, mid[ADDR_BITS-1:0], 21'd1);
        for (int k = 1; k < tbl_count; k++) begin
            if (tbl_first[k] - tbl_last[k - 1] >= 3) begin
                mid = tbl_last[k - 1] + 1'b1;
                send_cmd(CMD_FREE, mid[ADDR_BITS-1:0], 21'd1);
                break;
            end
        end
    endtask

    task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n_items) send_random_cmd();
    endtask

    // result side holds off for a long stretch while commands keep being offered
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_end = rx_cycle + 300;
        repeat (8) send_random_cmd();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_range_and_reserved();
        test_free_merge();
        test_carve();
        test_best_fit();
        test_table_full();
        test_random(300, 31, 85);
        test_random(300, 85, 31);
        test_backpressure();
        test_random(200, 0, 0);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/bfra_pkg.sv
rtl/bfra_cell.sv
rtl/best_fit_region_allocator_unit.sv
test/best_fit_region_allocator_unit_tb.sv
